// ----- design/psesu_pkg.sv -----
`timescale 1ns / 1ps

package psesu_pkg;

  localparam int SW_COUNT    = 7;
  localparam int CLICK_COUNT = 5;
  localparam int ENC_COUNT   = 4;
  localparam int LATCH_W     = SW_COUNT + CLICK_COUNT;

  localparam logic       CMD_INIT = 1'b0;
  localparam logic       CMD_POLL = 1'b1;

  localparam logic [6:0] ACTIVE_LOW_MASK = 7'h3C;
  localparam logic [7:0] PATTERN_UP      = 8'h12;
  localparam logic [7:0] PATTERN_DOWN    = 8'h21;
  localparam logic [1:0] PAIR_BOTH_HIGH  = 2'b11;

  typedef struct packed {
    logic upd;
    logic cmd;
  } psesu_ctl_t;

endpackage

// ----- design/panel_switch_and_encoder_scanner_unit.sv -----
`timescale 1ns / 1ps
// An accepted item passes through the input register, then the result register.
// Throughput: 1 item per cycle while out_stall is low; both registers advance together.
// Stall on the result side holds both registers; in_stall rises only when both are full
// and the result is stalled.
// Reset (synchronous, rst_n low): latch, histories, positions cleared, on_level set to 1.
// All pin and encoder state updates as an item moves from input to result register.

module panel_switch_and_encoder_scanner_unit import psesu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [6:0]  in_switch_pins,
  input  logic        in_tactile_pin,
  input  logic [3:0]  in_button_pins,
  input  logic [3:0]  in_phase_a_pins,
  input  logic [3:0]  in_phase_b_pins,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_switch_events,
  output logic [4:0]  out_click_events,
  output logic [7:0]  out_turn_events,
  output logic [7:0]  out_position_one,
  output logic [7:0]  out_position_two,
  output logic [7:0]  out_position_three,
  output logic [7:0]  out_position_four
);

  logic        on_level_r;
  logic        s1_valid_r;
  logic        s1_cmd_r;
  logic [6:0]  s1_sw_r;
  logic        s1_tac_r;
  logic [3:0]  s1_btn_r;
  logic [3:0]  s1_a_r;
  logic [3:0]  s1_b_r;
  logic        out_valid_r;
  logic        advance;
  logic        in_take;
  psesu_ctl_t  ctl;

  logic [13:0] sw_ev;
  logic [4:0]  click_ev;
  logic [7:0]  turn_ev;
  logic [7:0]  pos [ENC_COUNT];

  logic [13:0] sw_ev_r;
  logic [4:0]  click_ev_r;
  logic [7:0]  turn_ev_r;
  logic [7:0]  pos_r [ENC_COUNT];

  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign ctl.upd  = advance;
  assign ctl.cmd  = s1_cmd_r;

  psesu_switch u_switch (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .on_level      (on_level_r),
    .switch_pins   (s1_sw_r),
    .tactile_pin   (s1_tac_r),
    .button_pins   (s1_btn_r),
    .switch_events (sw_ev),
    .click_events  (click_ev)
  );

  for (genvar k = 0; k < ENC_COUNT; k++) begin : g_enc
    psesu_encoder u_enc (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .phase_a   (s1_a_r[k]),
      .phase_b   (s1_b_r[k]),
      .step_up   (turn_ev[2*k]),
      .step_down (turn_ev[2*k+1]),
      .pos_nxt   (pos[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_level_r  <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        on_level_r <= cfg_write_data;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= in_cmd;
      s1_sw_r  <= in_switch_pins;
      s1_tac_r <= in_tactile_pin;
      s1_btn_r <= in_button_pins;
      s1_a_r   <= in_phase_a_pins;
      s1_b_r   <= in_phase_b_pins;
    end
    if (advance) begin
      sw_ev_r    <= sw_ev;
      click_ev_r <= click_ev;
      turn_ev_r  <= turn_ev;
      for (int k = 0; k < ENC_COUNT; k++) begin
        pos_r[k] <= pos[k];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_switch_events  = sw_ev_r;
  assign out_click_events   = click_ev_r;
  assign out_turn_events    = turn_ev_r;
  assign out_position_one   = pos_r[0];
  assign out_position_two   = pos_r[1];
  assign out_position_three = pos_r[2];
  assign out_position_four  = pos_r[3];

`ifndef SYNTHESIS
  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_cmd_r == CMD_INIT) |=>
      (out_switch_events == '0 && out_click_events == '0 && out_turn_events == '0 &&
       out_position_one == '0 && out_position_two == '0 &&
       out_position_three == '0 && out_position_four == '0))
    else $error("init result not cleared");

  a_no_up_and_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_turn_events & (out_turn_events >> 1) & 8'h55) == 8'h00))
    else $error("encoder stepped both ways");

  a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted item lost in input register");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result not presented");
`endif

endmodule

// ----- design/psesu_switch.sv -----
`timescale 1ns / 1ps

module psesu_switch import psesu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  psesu_ctl_t               ctl,
  input  logic                     on_level,
  input  logic [SW_COUNT-1:0]      switch_pins,
  input  logic                     tactile_pin,
  input  logic [ENC_COUNT-1:0]     button_pins,
  output logic [2*SW_COUNT-1:0]    switch_events,
  output logic [CLICK_COUNT-1:0]   click_events
);

  logic [LATCH_W-1:0] latch_r;
  logic [LATCH_W-1:0] latch_nxt;
  logic [LATCH_W-1:0] diff;

  assign latch_nxt = {button_pins, tactile_pin, switch_pins ^ ACTIVE_LOW_MASK};
  assign diff      = latch_nxt ^ latch_r;

  always_comb begin
    switch_events = '0;
    click_events  = '0;
    if (ctl.cmd == CMD_POLL) begin
      for (int k = 0; k < SW_COUNT; k++) begin
        switch_events[2*k]   = diff[k] && (latch_nxt[k] == on_level);
        switch_events[2*k+1] = diff[k] && (latch_nxt[k] != on_level);
      end
      for (int k = 0; k < CLICK_COUNT; k++) begin
        click_events[k] = diff[SW_COUNT+k] && (latch_nxt[SW_COUNT+k] != on_level);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
    end else if (ctl.upd) begin
      latch_r <= latch_nxt;
    end
  end

endmodule

// ----- design/psesu_encoder.sv -----
`timescale 1ns / 1ps

module psesu_encoder import psesu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  psesu_ctl_t ctl,
  input  logic       phase_a,
  input  logic       phase_b,
  output logic       step_up,
  output logic       step_down,
  output logic [7:0] pos_nxt
);

  logic [7:0] hist_r;
  logic [7:0] hist_nxt;
  logic [7:0] pos_r;
  logic [1:0] pair;

  assign pair = {phase_a, phase_b};

  always_comb begin
    hist_nxt  = hist_r;
    pos_nxt   = pos_r;
    step_up   = 1'b0;
    step_down = 1'b0;
    if (ctl.cmd == CMD_INIT) begin
      pos_nxt = '0;
    end else if (hist_r[1:0] != pair) begin
      if (pair == PAIR_BOTH_HIGH) begin
        if (hist_r == PATTERN_UP) begin
          step_up = 1'b1;
          pos_nxt = pos_r + 8'd1;
        end else if (hist_r == PATTERN_DOWN) begin
          step_down = 1'b1;
          pos_nxt   = pos_r - 8'd1;
        end
        hist_nxt = '0;
      end else begin
        hist_nxt = {hist_r[5:0], pair};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      pos_r  <= '0;
    end else if (ctl.upd) begin
      hist_r <= hist_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// ----- verif/scan_result_checker.sv -----
`timescale 1ns / 1ps

module scan_result_checker import psesu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [6:0]  in_switch_pins,
  input  logic        in_tactile_pin,
  input  logic [3:0]  in_button_pins,
  input  logic [3:0]  in_phase_a_pins,
  input  logic [3:0]  in_phase_b_pins,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [13:0] out_switch_events,
  input  logic [4:0]  out_click_events,
  input  logic [7:0]  out_turn_events,
  input  logic [7:0]  out_position_one,
  input  logic [7:0]  out_position_two,
  input  logic [7:0]  out_position_three,
  input  logic [7:0]  out_position_four,
  output int          mismatches,
  output int          pending_results,
  output int          checked_results
);

  typedef struct packed {
    logic [13:0]               switch_events;
    logic [4:0]                click_events;
    logic [7:0]                turn_events;
    logic [ENC_COUNT-1:0][7:0] positions;
  } scan_result_t;

  scan_result_t          expected_scans[$];
  logic                  level_on;
  logic [LATCH_W-1:0]    pin_latch;
  logic [7:0]            phase_hist [ENC_COUNT];
  logic [7:0]            enc_pos    [ENC_COUNT];
  int                    error_total;
  int                    result_total;

  function automatic scan_result_t scan_snapshot(
    input logic       cmd,
    input logic [6:0] sw,
    input logic       tac,
    input logic [3:0] btn,
    input logic [3:0] pa,
    input logic [3:0] pb
  );
    scan_result_t       res;
    logic [LATCH_W-1:0] now;
    logic [1:0]         pair;
    logic [7:0]         hist;
    res = '0;
    now = {btn, tac, sw ^ ACTIVE_LOW_MASK};
    if (cmd == CMD_INIT) begin
      pin_latch = now;
      for (int k = 0; k < ENC_COUNT; k++) enc_pos[k] = 8'd0;
    end else begin
      for (int k = 0; k < SW_COUNT; k++) begin
        if (pin_latch[k] != now[k]) begin
          if (now[k] == level_on) res.switch_events[2*k] = 1'b1;
          else res.switch_events[2*k+1] = 1'b1;
        end
      end
      for (int k = 0; k < CLICK_COUNT; k++) begin
        if (pin_latch[SW_COUNT+k] != now[SW_COUNT+k] && now[SW_COUNT+k] != level_on)
          res.click_events[k] = 1'b1;
      end
      pin_latch = now;
      for (int k = 0; k < ENC_COUNT; k++) begin
        pair = {pa[k], pb[k]};
        hist = phase_hist[k];
        if (hist[1:0] != pair) begin
          if (pair == PAIR_BOTH_HIGH) begin
            if (hist == PATTERN_UP) begin
              enc_pos[k] = enc_pos[k] + 8'd1;
              res.turn_events[2*k] = 1'b1;
            end else if (hist == PATTERN_DOWN) begin
              enc_pos[k] = enc_pos[k] - 8'd1;
              res.turn_events[2*k+1] = 1'b1;
            end
            phase_hist[k] = 8'd0;
          end else begin
            phase_hist[k] = {hist[5:0], pair};
          end
        end
      end
    end
    for (int k = 0; k < ENC_COUNT; k++) res.positions[k] = enc_pos[k];
    return res;
  endfunction

  function automatic int check_field(input string name, input int unsigned want,
                                     input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      level_on  = 1'b1;
      pin_latch = '0;
      for (int k = 0; k < ENC_COUNT; k++) begin
        phase_hist[k] = 8'd0;
        enc_pos[k]    = 8'd0;
      end
      expected_scans.delete();
      error_total  = 0;
      result_total = 0;
    end else begin
      if (cfg_write_en) level_on = cfg_write_data;
      if (out_valid && !out_stall) begin
        if (expected_scans.size() == 0) begin
          $error("result item arrived with no item outstanding");
          error_total++;
        end else begin
          want = expected_scans.pop_front();
          error_total += check_field("switch_events", 32'(want.switch_events),
                                     32'(out_switch_events));
          error_total += check_field("click_events", 32'(want.click_events),
                                     32'(out_click_events));
          error_total += check_field("turn_events", 32'(want.turn_events),
                                     32'(out_turn_events));
          error_total += check_field("position_one", 32'(want.positions[0]),
                                     32'(out_position_one));
          error_total += check_field("position_two", 32'(want.positions[1]),
                                     32'(out_position_two));
          error_total += check_field("position_three", 32'(want.positions[2]),
                                     32'(out_position_three));
          error_total += check_field("position_four", 32'(want.positions[3]),
                                     32'(out_position_four));
          result_total++;
        end
      end
      if (in_valid && !in_stall)
        expected_scans.push_back(scan_snapshot(in_cmd, in_switch_pins, in_tactile_pin,
                                               in_button_pins, in_phase_a_pins,
                                               in_phase_b_pins));
    end
    mismatches      <= error_total;
    pending_results <= expected_scans.size();
    checked_results <= result_total;
  end

endmodule

// ----- verif/panel_switch_and_encoder_scanner_unit_tb.sv -----
`timescale 1ns / 1ps

module panel_switch_and_encoder_scanner_unit_tb import psesu_pkg::*; ();

  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_ITEMS   = 320;
  localparam logic [3:0][1:0] GRAY_WALK = {2'b10, 2'b00, 2'b01, 2'b11};

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        cfg_write_en       = 1'b0;
  logic        cfg_write_data     = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic        in_cmd             = CMD_INIT;
  logic [6:0]  in_switch_pins     = '0;
  logic        in_tactile_pin     = 1'b0;
  logic [3:0]  in_button_pins     = '0;
  logic [3:0]  in_phase_a_pins    = '0;
  logic [3:0]  in_phase_b_pins    = '0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic [13:0] out_switch_events;
  logic [4:0]  out_click_events;
  logic [7:0]  out_turn_events;
  logic [7:0]  out_position_one;
  logic [7:0]  out_position_two;
  logic [7:0]  out_position_three;
  logic [7:0]  out_position_four;

  int mismatches;
  int pending_results;
  int checked_results;
  int stall_pct   = 0;
  int idle_pct    = 0;
  int quiet_cycles = 0;
  int init_items  = 0;
  int poll_items  = 0;

  always #1 clk = ~clk;

  panel_switch_and_encoder_scanner_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_switch_pins     (in_switch_pins),
    .in_tactile_pin     (in_tactile_pin),
    .in_button_pins     (in_button_pins),
    .in_phase_a_pins    (in_phase_a_pins),
    .in_phase_b_pins    (in_phase_b_pins),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_switch_events  (out_switch_events),
    .out_click_events   (out_click_events),
    .out_turn_events    (out_turn_events),
    .out_position_one   (out_position_one),
    .out_position_two   (out_position_two),
    .out_position_three (out_position_three),
    .out_position_four  (out_position_four)
  );

  scan_result_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_switch_pins     (in_switch_pins),
    .in_tactile_pin     (in_tactile_pin),
    .in_button_pins     (in_button_pins),
    .in_phase_a_pins    (in_phase_a_pins),
    .in_phase_b_pins    (in_phase_b_pins),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_switch_events  (out_switch_events),
    .out_click_events   (out_click_events),
    .out_turn_events    (out_turn_events),
    .out_position_one   (out_position_one),
    .out_position_two   (out_position_two),
    .out_position_three (out_position_three),
    .out_position_four  (out_position_four),
    .mismatches         (mismatches),
    .pending_results    (pending_results),
    .checked_results    (checked_results)
  );

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_snapshot(input logic cmd, input logic [6:0] sw, input logic tac,
                               input logic [3:0] btn, input logic [3:0] pa,
                               input logic [3:0] pb);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_switch_pins  <= sw;
    in_tactile_pin  <= tac;
    in_button_pins  <= btn;
    in_phase_a_pins <= pa;
    in_phase_b_pins <= pb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_INIT) init_items++;
    else poll_items++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_on_level(input logic level);
    drain_results();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= level;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  initial begin
    logic [6:0] sw_lvl;
    logic       tac_lvl;
    logic [3:0] btn_lvl;
    logic [3:0] pa;
    logic [3:0] pb;
    logic       cmd;
    logic [1:0] pair;
    int         walk_idx [ENC_COUNT];
    int         fwd_pct  [ENC_COUNT];
    int         roll;
    int         idle_plan  [PHASE_COUNT];
    int         stall_plan [PHASE_COUNT];

    idle_plan  = '{0, 66, 0, 35, 0, 66};
    stall_plan = '{0, 0, 66, 35, 0, 66};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_snapshot(CMD_INIT, 7'h00, 1'b0, 4'h0, 4'h0, 4'h0);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'hF, 4'hF);
    send_snapshot(CMD_POLL, 7'h00, 1'b0, 4'h0, 4'hF, 4'hF);
    send_snapshot(CMD_INIT, 7'h7F, 1'b1, 4'hF, 4'hF, 4'hF);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'b1010, 4'b0101);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'b0000, 4'b0000);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'b0101, 4'b1010);
    // init mid-walk: positions clear, histories carry on
    send_snapshot(CMD_INIT, 7'h7F, 1'b1, 4'hF, 4'h0, 4'h0);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'hF, 4'hF);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'b0101, 4'b1010);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'b0000, 4'b0000);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'b1010, 4'b0101);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'hF, 4'hF);
    // broken pattern: clear without a step
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'h0, 4'hF);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'hF, 4'hF);
    send_snapshot(CMD_POLL, 7'h55, 1'b0, 4'h5, 4'hF, 4'hF);
    send_snapshot(CMD_POLL, 7'h2A, 1'b1, 4'hA, 4'hF, 4'hF);
    write_on_level(1'b0);
    send_snapshot(CMD_POLL, 7'h55, 1'b0, 4'h5, 4'hF, 4'hF);
    send_snapshot(CMD_POLL, 7'h2A, 1'b1, 4'hA, 4'hF, 4'hF);
    send_snapshot(CMD_POLL, 7'h00, 1'b0, 4'h0, 4'hF, 4'hF);
    send_snapshot(CMD_POLL, 7'h7F, 1'b1, 4'hF, 4'hF, 4'hF);

    sw_lvl  = 7'h7F;
    tac_lvl = 1'b1;
    btn_lvl = 4'hF;
    for (int k = 0; k < ENC_COUNT; k++) walk_idx[k] = 0;

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_on_level((ph % 2) == 0);
      idle_pct  = idle_plan[ph];
      stall_pct <= stall_plan[ph];
      for (int k = 0; k < ENC_COUNT; k++) fwd_pct[k] = $urandom_range(15, 75);
      repeat (PHASE_ITEMS) begin
        cmd = ($urandom_range(0, 99) < 3) ? CMD_INIT : CMD_POLL;
        if ($urandom_range(0, 2) == 0) sw_lvl[$urandom_range(0, 6)] ^= 1'b1;
        if ($urandom_range(0, 6) == 0) tac_lvl = ~tac_lvl;
        if ($urandom_range(0, 3) == 0) btn_lvl[$urandom_range(0, 3)] ^= 1'b1;
        for (int k = 0; k < ENC_COUNT; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < fwd_pct[k]) walk_idx[k] = (walk_idx[k] + 1) % 4;
          else if (roll < 85) walk_idx[k] = (walk_idx[k] + 3) % 4;
          else if (roll >= 94) walk_idx[k] = $urandom_range(0, 3);
          pair = GRAY_WALK[walk_idx[k]];
          pa[k] = pair[1];
          pb[k] = pair[0];
        end
        // occasional fully random snapshot
        if ($urandom_range(0, 99) < 5) begin
          sw_lvl  = 7'($urandom_range(0, 127));
          tac_lvl = 1'($urandom_range(0, 1));
          btn_lvl = 4'($urandom_range(0, 15));
          pa      = 4'($urandom_range(0, 15));
          pb      = 4'($urandom_range(0, 15));
        end
        send_snapshot(cmd, sw_lvl, tac_lvl, btn_lvl, pa, pb);
      end
    end

    drain_results();
    stall_pct <= 0;
    repeat (4) @(posedge clk);
    $display("Sent %0d init and %0d poll snapshots under both on levels and six idle/stall mixes",
             init_items, poll_items);
    $display("Compared %0d result items against the predicted scan", checked_results);
    if (mismatches == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
